FILE: design/luhn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared widths, constants, types and helper functions for the card number
// Luhn checker and issuer classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

    // Field widths.
    localparam int CARD_W   = 63;
    localparam int CNT_W    = 5;
    localparam int CLS_W    = 2;

    // Decimal digits needed to hold any CARD_W-bit number.
    localparam int DIGITS   = 19;
    localparam int BCD_W    = DIGITS * 4;

    // Default for the longest number the checker accepts.
    localparam int MAX_DIGITS_DEF = 19;

    // Binary-to-decimal conversion: input bits consumed per pipeline stage.
    localparam int BITS_PER_STG = 4;
    localparam int CNV_STG      = (CARD_W + BITS_PER_STG - 1) / BITS_PER_STG;
    localparam int PAD_W        = CNV_STG * BITS_PER_STG;
    localparam int DD_W         = BCD_W + PAD_W;

    // Luhn partial sums: digits per group, groups, and sum widths.
    localparam int GRP      = 5;
    localparam int NGRP     = (DIGITS + GRP - 1) / GRP;
    localparam int PART_W   = 6;
    localparam int SUM_W    = 8;

    // Digit counts that the issuer rules look at.
    localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [CNT_W-1:0] LEN_16 = 5'd16;

    // Issuer classes.
    typedef enum logic [CLS_W-1:0] {
        CLS_NONE  = 2'd0,
        CLS_PFX3  = 2'd1,
        CLS_PFX4  = 2'd2,
        CLS_PFX5  = 2'd3
    } t_issuer;

    // One double-dabble step: correct every BCD digit of 5 or more by 3,
    // then shift the whole BCD and binary word left by one bit.
    function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] v);
        logic [DD_W-1:0] t;
        t = v;
        for (int i = 0; i < DIGITS; i++) begin
            if (t[PAD_W + i*4 +: 4] >= 4'd5) begin
                t[PAD_W + i*4 +: 4] = t[PAD_W + i*4 +: 4] + 4'd3;
            end
        end
        return {t[DD_W-2:0], 1'b0};
    endfunction

    // Luhn value of a doubled digit: twice the digit, less 9 above 9.
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    // True when s is a multiple of ten; quotient by reciprocal 205/2048,
    // exact for every 8-bit value.
    function automatic logic mod10_zero(input logic [SUM_W-1:0] s);
        logic [15:0]      p;
        logic [4:0]       q;
        logic [SUM_W-1:0] q10;
        p   = {8'd0, s} * 16'd205;
        q   = p[15:11];
        q10 = {q, 3'b000} + {2'b00, q, 1'b0};
        return (s - q10) == '0;
    endfunction

endpackage

FILE: design/card_number_luhn_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_top
// Luhn mod-10 check and issuer classification of binary card numbers.
// ----------------------------------------------------------------------------
// The block takes one 63-bit binary card number per cycle while the output
// is not stalled and returns, for each, the Luhn check result, an issuer
// class and the decimal digit count. It is fully pipelined: a new item is
// accepted in every cycle unless back pressure holds the pipe. Each item
// passes through binary-to-decimal conversion stages at four bits per
// stage, then a digit count and partial sum stage, a lead digit and total
// sum stage, and the output register. Each stage holds its item while the
// next is full, so back pressure on the output stalls the pipe without
// loss and empty stages fill up. A zero number gives a digit count of 0 and
// fails the check; the issuer class is always 0 when the check fails.
module card_number_luhn_classifier_top
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CARD_W-1:0] i_card_number,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_checksum_ok,
    output logic [CLS_W-1:0]  o_issuer_class,
    output logic [CNT_W-1:0]  o_digit_count
);

    // Stage indexes after the conversion stages.
    localparam int S_P1  = CNV_STG;
    localparam int S_P2  = CNV_STG + 1;
    localparam int S_OUT = CNV_STG + 2;
    localparam int NSTG  = CNV_STG + 3;

    // Stage valid bits and per-stage readiness.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_prev_vld;

    // Conversion stage registers and their next values.
    logic [DD_W-1:0] r_cv_dat [CNV_STG];
    logic [DD_W-1:0] n_cv_dat [CNV_STG];

    // First post-conversion stage.
    logic [BCD_W-1:0]  r_p1_dig;
    logic [CNT_W-1:0]  r_p1_cnt;
    logic [PART_W-1:0] r_p1_part [NGRP];
    logic [BCD_W-1:0]  n_p1_dig;
    logic [CNT_W-1:0]  n_p1_cnt;
    logic [PART_W-1:0] n_p1_part [NGRP];

    // Second post-conversion stage.
    logic [SUM_W-1:0] r_p2_sum;
    logic [3:0]       r_p2_lead;
    logic [3:0]       r_p2_next;
    logic [CNT_W-1:0] r_p2_cnt;
    logic [SUM_W-1:0] n_p2_sum;
    logic [3:0]       n_p2_lead;
    logic [3:0]       n_p2_next;

    // Output register.
    logic             r_ok;
    t_issuer          r_cls;
    logic [CNT_W-1:0] r_cnt;
    logic             n_ok;
    t_issuer          n_cls;

    // A stage can take an item when it is empty or its item moves on.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_prev_vld = {r_vld[NSTG-2:0], i_in_valid};
    end

    // Valid bits move with their items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_prev_vld[k];
                end
            end
        end
    end

    // Conversion stages: each runs four double-dabble steps.
    always_comb begin
        logic [DD_W-1:0] t;
        for (int k = 0; k < CNV_STG; k++) begin
            if (k == 0) begin
                t = {{BCD_W{1'b0}}, {(PAD_W - CARD_W){1'b0}}, i_card_number};
            end else begin
                t = r_cv_dat[k-1];
            end
            for (int b = 0; b < BITS_PER_STG; b++) begin
                t = dd_step(t);
            end
            n_cv_dat[k] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CNV_STG; k++) begin
            if (w_rdy[k] && w_prev_vld[k]) begin
                r_cv_dat[k] <= n_cv_dat[k];
            end
        end
    end

    // Digit count from the highest nonzero digit, and Luhn partial sums
    // over groups of digits; every second digit from the right, starting at the second, is doubled.
    always_comb begin
        logic [3:0] d;
        n_p1_dig = r_cv_dat[CNV_STG-1][DD_W-1 -: BCD_W];
        n_p1_cnt = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (n_p1_dig[i*4 +: 4] != 4'd0) begin
                n_p1_cnt = CNT_W'(i + 1);
            end
        end
        for (int g = 0; g < NGRP; g++) begin
            n_p1_part[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g*GRP + j < DIGITS) begin
                    d = n_p1_dig[(g*GRP + j)*4 +: 4];
                    if (((g*GRP + j) % 2) == 1) begin
                        d = luhn_dbl(d);
                    end
                    n_p1_part[g] = n_p1_part[g] + {2'b00, d};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_P1] && w_prev_vld[S_P1]) begin
            r_p1_dig  <= n_p1_dig;
            r_p1_cnt  <= n_p1_cnt;
            r_p1_part <= n_p1_part;
        end
    end

    // Total Luhn sum and the two leading digits.
    always_comb begin
        n_p2_sum  = '0;
        n_p2_lead = '0;
        n_p2_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_p2_sum = n_p2_sum + {{(SUM_W - PART_W){1'b0}}, r_p1_part[g]};
        end
        for (int i = 0; i < DIGITS; i++) begin
            if (r_p1_cnt == CNT_W'(i + 1)) begin
                n_p2_lead = r_p1_dig[i*4 +: 4];
            end
            if (r_p1_cnt == CNT_W'(i + 2)) begin
                n_p2_next = r_p1_dig[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_P2] && w_prev_vld[S_P2]) begin
            r_p2_sum  <= n_p2_sum;
            r_p2_lead <= n_p2_lead;
            r_p2_next <= n_p2_next;
            r_p2_cnt  <= r_p1_cnt;
        end
    end

    // Pass or fail, then issuer class from length and prefix.
    always_comb begin
        n_ok  = (r_p2_cnt != '0) && (r_p2_cnt <= CNT_W'(MAX_DIGITS))
                && mod10_zero(r_p2_sum);
        n_cls = CLS_NONE;
        if (n_ok) begin
            if (r_p2_cnt == LEN_15 && r_p2_lead == 4'd3
                && (r_p2_next == 4'd4 || r_p2_next == 4'd7)) begin
                n_cls = CLS_PFX3;
            end else if ((r_p2_cnt == LEN_13 || r_p2_cnt == LEN_16)
                         && r_p2_lead == 4'd4) begin
                n_cls = CLS_PFX4;
            end else if (r_p2_cnt == LEN_16 && r_p2_lead == 4'd5
                         && r_p2_next >= 4'd1 && r_p2_next <= 4'd5) begin
                n_cls = CLS_PFX5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_OUT] && w_prev_vld[S_OUT]) begin
            r_ok  <= n_ok;
            r_cls <= n_cls;
            r_cnt <= r_p2_cnt;
        end
    end

    // Ports.
    assign o_in_ready     = w_rdy[0];
    assign o_out_valid    = r_vld[S_OUT];
    assign o_checksum_ok  = r_ok;
    assign o_issuer_class = r_cls;
    assign o_digit_count  = r_cnt;

endmodule
